// ===== sv/multichannel_resampling_mixer_assert.svh =====
// Assertion macros for the resampling mixer.
// Used by the back-end and top-level modules; no other dependencies.
`ifndef MULTICHANNEL_RESAMPLING_MIXER_ASSERT_SVH
`define MULTICHANNEL_RESAMPLING_MIXER_ASSERT_SVH
// implication checked every clock outside reset
`define MRM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define MRM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== sv/mrm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the resampling mixer.
// No dependencies.
package mrm_pkg;
  localparam int CHANNELS_DEF    = 8;
  localparam int STORE_DEPTH_DEF = 4096;
  localparam int FRAC_BITS       = 10;
  localparam int HEADROOM_BITS   = 4;
  localparam int SUM_W           = 40;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2,
    KIND_MIX   = 2'd3
  } kind_t;

  localparam logic [1:0] REG_STEREO = 2'd0;
  localparam logic [1:0] REG_EIGHT  = 2'd1;
  localparam logic [1:0] REG_SIGNED = 2'd2;
  localparam logic [1:0] REG_PAUSE  = 2'd3;

  // one command word as held in the queue between front and back
  typedef struct packed {
    kind_t        kind;
    logic [6:0]   channel;
    logic         chan_ok;
    logic [15:0]  address;
    logic [15:0]  sample_left;
    logic [15:0]  sample_right;
    logic [22:0]  channel_length;
    logic [15:0]  step_delta;
    logic [12:0]  left_volume;
    logic [12:0]  right_volume;
    logic         loop_once;
  } cmd_t;

  typedef struct packed {
    logic       stereo;
    logic       eight;
    logic       sgn;
    logic [7:0] paused;
  } cfg_t;

  // saturate and scale one frame sum
  function automatic logic [16:0] to_format(input logic signed [SUM_W-1:0] v,
                                            input logic eight, input logic sgn);
    logic signed [SUM_W-1:0] lim;
    logic signed [SUM_W-1:0] c;
    logic [SUM_W-1:0] biased;
    logic [16:0] s;
    lim = (SUM_W'(1) <<< (31 - HEADROOM_BITS)) - SUM_W'(1);
    c = v;
    if (v > lim) c = lim;
    if (v < -lim) c = -lim;
    biased = c + lim + SUM_W'(1);
    if (eight) begin
      s = 17'(biased >> (24 - HEADROOM_BITS));
      if (sgn) s = s - 17'h80;
    end else begin
      s = 17'(biased >> (16 - HEADROOM_BITS));
      if (sgn) s = s - 17'h8000;
    end
    return s;
  endfunction
endpackage

// ===== sv/mrm_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input words, classifies them, pushes into a 2-entry queue.
// Depends on mrm_pkg.
module mrm_front #(
  parameter int CHANNELS    = mrm_pkg::CHANNELS_DEF,
  parameter int STORE_DEPTH = mrm_pkg::STORE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_kind,
  input  logic [2:0]        in_channel,
  input  logic [11:0]       in_address,
  input  logic signed [15:0] in_sample_left,
  input  logic signed [15:0] in_sample_right,
  input  logic [22:0]       in_channel_length,
  input  logic [15:0]       in_step_delta,
  input  logic [12:0]       in_left_volume,
  input  logic [12:0]       in_right_volume,
  input  logic              in_loop_once,
  output logic              q_valid,
  input  logic              q_ready,
  output mrm_pkg::cmd_t     q_cmd
);
  localparam int AW = $clog2(STORE_DEPTH);
  mrm_pkg::cmd_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  mrm_pkg::cmd_t cmd;
  logic push, pop;

  always_comb begin
    cmd = '0;
    cmd.kind           = mrm_pkg::kind_t'(in_kind);
    cmd.channel        = 7'(in_channel);
    cmd.chan_ok        = (32'(in_channel) < CHANNELS);
    cmd.address        = 16'(in_address[AW-1 < 11 ? AW-1 : 11 : 0]);
    cmd.sample_left    = in_sample_left;
    cmd.sample_right   = in_sample_right;
    cmd.channel_length = in_channel_length;
    cmd.step_delta     = in_step_delta;
    cmd.left_volume    = in_left_volume;
    cmd.right_volume   = in_right_volume;
    cmd.loop_once      = in_loop_once;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_cmd = q_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
    rd_nxt = rd_r ^ pop;
    wr_nxt = wr_r ^ push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r <= rd_nxt;
      wr_r <= wr_nxt;
    end
    if (push) q_r[wr_r] <= cmd;
  end
endmodule

// ===== sv/mrm_back.sv =====
`timescale 1ns / 1ps
// Back end: sample store, channel state and the per-channel multiply-accumulate walk.
// Depends on mrm_pkg and the assertion header.
`include "multichannel_resampling_mixer_assert.svh"
module mrm_back #(
  parameter int CHANNELS    = mrm_pkg::CHANNELS_DEF,
  parameter int STORE_DEPTH = mrm_pkg::STORE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  mrm_pkg::cmd_t      q_cmd,
  input  mrm_pkg::cfg_t      cfg,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] out_left,
  output logic signed [16:0] out_right,
  output logic [7:0]         out_finished_mask
);
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SW = mrm_pkg::SUM_W;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SEL  = 5'b00010,
    ST_RD   = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_ACC  = 5'b10000
  } st_t;

  logic [31:0] store [STORE_DEPTH];
  logic [22:0] offs_r [CHANNELS];
  logic [15:0] step_r [CHANNELS];
  logic [22:0] end_r  [CHANNELS];
  logic [AW-1:0] base_r [CHANNELS];
  logic [12:0] gl_r [CHANNELS];
  logic [12:0] gr_r [CHANNELS];
  logic [CHANNELS-1:0] loop_r, act_r, done_r;

  st_t state_r, state_nxt;
  logic [CW:0] idx_r;
  logic [CW-1:0] ch;
  logic [31:0] word_r;
  logic signed [29:0] pl_r, pr_r;
  logic signed [SW-1:0] suml_r, sumr_r;
  logic ov_r;
  logic signed [16:0] ol_r, or_r;
  logic [7:0] om_r;
  logic live;
  logic [22:0] nxt;
  logic [7:0] dmask;

  assign ch = idx_r[CW-1:0];
  assign live = act_r[ch] && !(32'(ch) < 8 && cfg.paused[3'(ch)]) &&
                (gl_r[ch] != 0 || gr_r[ch] != 0);
  assign nxt = offs_r[ch] + 23'(step_r[ch]);
  assign q_ready = (state_r == ST_IDLE) &&
                   (q_cmd.kind != mrm_pkg::KIND_MIX || !ov_r || out_ready);

  always_comb begin
    dmask = '0;
    for (int i = 0; i < CHANNELS && i < 8; i++) dmask[i] = done_r[i];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (q_valid && q_ready && q_cmd.kind == mrm_pkg::KIND_MIX) state_nxt = ST_SEL;
      ST_SEL: begin
        if (idx_r == (CW+1)'(CHANNELS)) state_nxt = ST_IDLE;
        else if (live) state_nxt = ST_RD;
      end
      ST_RD:  state_nxt = ST_MUL;
      ST_MUL: state_nxt = ST_ACC;
      ST_ACC: state_nxt = ST_SEL;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready && q_cmd.kind == mrm_pkg::KIND_WRITE)
      store[q_cmd.address[AW-1:0]] <= {q_cmd.sample_right, q_cmd.sample_left};
    if (state_r == ST_SEL && live)
      word_r <= store[base_r[ch] + AW'(offs_r[ch] >> mrm_pkg::FRAC_BITS)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r <= '0;
      ov_r <= 1'b0;
      loop_r <= '0;
      act_r <= '0;
      done_r <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        offs_r[i] <= '0; step_r[i] <= '0; end_r[i] <= '0;
        base_r[i] <= '0; gl_r[i] <= '0; gr_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (ov_r && out_ready) ov_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (q_valid && q_ready) begin
            case (q_cmd.kind)
              mrm_pkg::KIND_START: if (q_cmd.chan_ok) begin
                base_r[q_cmd.channel[CW-1:0]] <= q_cmd.address[AW-1:0];
                end_r[q_cmd.channel[CW-1:0]]  <= q_cmd.channel_length;
                step_r[q_cmd.channel[CW-1:0]] <= q_cmd.step_delta;
                gl_r[q_cmd.channel[CW-1:0]]   <= q_cmd.left_volume;
                gr_r[q_cmd.channel[CW-1:0]]   <= q_cmd.right_volume;
                loop_r[q_cmd.channel[CW-1:0]] <= q_cmd.loop_once;
                offs_r[q_cmd.channel[CW-1:0]] <= '0;
                act_r[q_cmd.channel[CW-1:0]]  <= 1'b1;
                done_r[q_cmd.channel[CW-1:0]] <= 1'b0;
              end
              mrm_pkg::KIND_STOP: if (q_cmd.chan_ok) begin
                act_r[q_cmd.channel[CW-1:0]]  <= 1'b0;
                done_r[q_cmd.channel[CW-1:0]] <= 1'b0;
              end
              mrm_pkg::KIND_MIX: begin
                idx_r <= '0;
                suml_r <= '0;
                sumr_r <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_SEL: begin
          if (idx_r == (CW+1)'(CHANNELS)) begin
            ol_r <= mrm_pkg::to_format(suml_r, cfg.eight, cfg.sgn);
            or_r <= cfg.stereo ? mrm_pkg::to_format(sumr_r, cfg.eight, cfg.sgn) : '0;
            om_r <= dmask;
            ov_r <= 1'b1;
          end else if (!live) begin
            idx_r <= idx_r + 1'b1;
          end else begin
            // advance the offset; wrap or finish at the end point
            if (nxt >= end_r[ch]) begin
              offs_r[ch] <= '0;
              if (loop_r[ch]) loop_r[ch] <= 1'b0;
              else begin
                act_r[ch] <= 1'b0;
                done_r[ch] <= 1'b1;
              end
            end else offs_r[ch] <= nxt;
          end
        end
        ST_MUL: begin
          pl_r <= $signed(word_r[15:0]) * $signed({1'b0, gl_r[ch]});
          pr_r <= $signed(word_r[31:16]) * $signed({1'b0, gr_r[ch]});
        end
        ST_ACC: begin
          suml_r <= suml_r + SW'(pl_r);
          if (cfg.stereo) sumr_r <= sumr_r + SW'(pr_r);
          idx_r <= idx_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = ov_r;
  assign out_left = ol_r;
  assign out_right = or_r;
  assign out_finished_mask = om_r;

  `MRM_ASSERT_IMP(a_nomix_busy, state_r != ST_IDLE, !q_ready)
  `MRM_ASSERT_NXT(a_rd_mul, state_r == ST_RD, state_r == ST_MUL)
  `MRM_ASSERT_IMP(a_act_done, 1'b1, (act_r & done_r) == '0)
endmodule

// ===== sv/multichannel_resampling_mixer.sv =====
`timescale 1ns / 1ps
// Top level of the resampling mixer: APB register block, front end and back end.
// Depends on mrm_pkg, mrm_front, mrm_back and the assertion header.
//
// Write, start and stop words are handled in the back end's idle state. A mix
// word walks channels one at a time through one shared multiply-accumulate:
// an idle, paused or silent channel is skipped in the select step, a playing
// channel goes through select/store read, sample register, multiply and
// accumulate, and a final select step formats the result. The
// store is read once per playing channel and written once per write word.
// A two-word queue lets the input side keep accepting while the back end works,
// and the result register lets write, start and stop words go on while the
// result waits; the next mix word waits until the result is taken.
`include "multichannel_resampling_mixer_assert.svh"
module multichannel_resampling_mixer #(
  parameter int CHANNELS    = mrm_pkg::CHANNELS_DEF,
  parameter int STORE_DEPTH = mrm_pkg::STORE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic [2:0]         in_channel,
  input  logic [11:0]        in_address,
  input  logic signed [15:0] in_sample_left,
  input  logic signed [15:0] in_sample_right,
  input  logic [22:0]        in_channel_length,
  input  logic [15:0]        in_step_delta,
  input  logic [12:0]        in_left_volume,
  input  logic [12:0]        in_right_volume,
  input  logic               in_loop_once,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] out_left,
  output logic signed [16:0] out_right,
  output logic [7:0]         out_finished_mask,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  mrm_pkg::cfg_t cfg_r;
  logic q_valid, q_ready;
  mrm_pkg::cmd_t q_cmd;
  logic wr;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  // register file: hold config, update on APB access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stereo <= 1'b1;
      cfg_r.eight  <= 1'b0;
      cfg_r.sgn    <= 1'b1;
      cfg_r.paused <= '0;
    end else if (wr) begin
      case (cfg_paddr[3:2])
        mrm_pkg::REG_STEREO: cfg_r.stereo <= cfg_pwdata[0];
        mrm_pkg::REG_EIGHT:  cfg_r.eight  <= cfg_pwdata[0];
        mrm_pkg::REG_SIGNED: cfg_r.sgn    <= cfg_pwdata[0];
        mrm_pkg::REG_PAUSE:  cfg_r.paused <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    case (cfg_paddr[3:2])
      mrm_pkg::REG_STEREO: cfg_prdata = 32'(cfg_r.stereo);
      mrm_pkg::REG_EIGHT:  cfg_prdata = 32'(cfg_r.eight);
      mrm_pkg::REG_SIGNED: cfg_prdata = 32'(cfg_r.sgn);
      mrm_pkg::REG_PAUSE:  cfg_prdata = 32'(cfg_r.paused);
      default: cfg_prdata = '0;
    endcase
  end

  mrm_front #(.CHANNELS(CHANNELS), .STORE_DEPTH(STORE_DEPTH)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_channel, .in_address,
    .in_sample_left, .in_sample_right, .in_channel_length, .in_step_delta,
    .in_left_volume, .in_right_volume, .in_loop_once,
    .q_valid, .q_ready, .q_cmd
  );

  mrm_back #(.CHANNELS(CHANNELS), .STORE_DEPTH(STORE_DEPTH)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_cmd, .cfg(cfg_r),
    .out_valid, .out_ready, .out_left, .out_right, .out_finished_mask
  );

  `MRM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_left))
  `MRM_ASSERT_IMP(a_mono_zero, out_valid && !cfg_r.stereo && !$past(wr), out_right == '0)
endmodule
